>>> src/stereo_multitap_reverb_core_macros.svh
// Assertion helpers shared by the reverb RTL.
`ifndef STEREO_MULTITAP_REVERB_CORE_MACROS_SVH
`define STEREO_MULTITAP_REVERB_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SMR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SMR_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) else $error(msg);

`endif

>>> src/smr_pkg.sv
package smr_pkg;

  localparam int unsigned DelayFramesDef = 12000;
  localparam int unsigned SampleBitsDef  = 24;
  localparam int unsigned TapCount       = 125;
  localparam int unsigned TapSpacing     = 5;
  localparam int unsigned ReadWrapStart  = 620;
  localparam int unsigned WetBits        = 16;
  localparam int unsigned OutBits        = 24;
  localparam int unsigned AccBits        = 27;

  localparam logic [0:0] RegWetLevel = 1'b0;

  typedef enum logic [5:0] {
    StClear = 6'b000001,
    StIdle  = 6'b000010,
    StTaps  = 6'b000100,
    StDiv   = 6'b001000,
    StMix   = 6'b010000,
    StOut   = 6'b100000
  } state_e;

  // Control from the sequencer to each channel lane.
  typedef struct packed {
    logic acc_clear;   // start a new tap sum
    logic acc_add;     // add the registered tap word
    logic div_start;   // latch the reciprocal product for the /125 step
    logic acc_load;    // load the /125 quotient into the accumulator
    logic mix_start;   // load the divider for the mix step
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
  } lane_stat_t;

endpackage

>>> src/smr_divider.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
module smr_divider #(
  parameter int unsigned NumBits = 48,
  parameter int unsigned DenBits = 18
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [NumBits-1:0] num_i,
  input  logic        [DenBits-1:0] den_i,
  output logic                      busy_o,
  output logic signed [NumBits-1:0] quot_o
);

  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] mag_q, mag_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic               neg_q, neg_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [DenBits:0]   shifted;
  logic [DenBits:0]   diff;

  always_comb begin
    mag_d   = mag_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    shifted = {rem_q[DenBits-1:0], mag_q[NumBits-1]};
    diff    = shifted - {1'b0, den_q};
    if (start_i) begin
      mag_d = num_i[NumBits-1] ? NumBits'(-num_i) : num_i;
      neg_d = num_i[NumBits-1];
      den_d = den_i;
      rem_d = '0;
      cnt_d = CntBits'(NumBits);
    end else if (cnt_q != '0) begin
      if (!diff[DenBits]) begin
        rem_d = diff;
        mag_d = {mag_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        mag_d = {mag_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = neg_q ? NumBits'(-mag_q) : mag_q;

endmodule

>>> src/smr_lane.sv
// One channel: delay memory, tap accumulator, /125 and mix divider.
`include "stereo_multitap_reverb_core_macros.svh"
module smr_lane #(
  parameter int unsigned DelayFrames = smr_pkg::DelayFramesDef,
  parameter int unsigned SampleBits  = smr_pkg::SampleBitsDef,
  parameter int unsigned AddrBits    = $clog2(DelayFrames)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [AddrBits-1:0]          waddr_i,
  input  logic signed [SampleBits-1:0] wdata_i,
  input  logic [AddrBits-1:0]          raddr_i,
  input  smr_pkg::lane_ctrl_t          ctrl_i,
  input  logic                         mix_sel_i,
  input  logic signed [SampleBits-1:0] x_i,
  input  logic [smr_pkg::WetBits-1:0]  wet_i,
  output smr_pkg::lane_stat_t          stat_o,
  output logic signed [smr_pkg::OutBits-1:0] y_o
);

  localparam int unsigned SumBits = SampleBits + 8;
  localparam int unsigned NumBits = SampleBits + smr_pkg::WetBits + 10;
  localparam int unsigned DenBits = smr_pkg::WetBits + 2;
  localparam logic signed [NumBits-1:0] OutMax = NumBits'(2**(smr_pkg::OutBits-1) - 1);
  localparam logic signed [NumBits-1:0] OutMin = -NumBits'(2**(smr_pkg::OutBits-1));
  // |acc + tap sum| stays below 126 full-scale samples, so MagBits covers it.
  // The reciprocal with RecShift = MagBits + 7 gives the exact floor quotient.
  localparam int unsigned MagBits  = SampleBits + 6;
  localparam int unsigned RecShift = MagBits + 7;
  localparam longint unsigned RecipFull =
    ((64'd1 << RecShift) + 64'(smr_pkg::TapCount) - 64'd1) / 64'(smr_pkg::TapCount);
  localparam logic [MagBits:0] Recip = (MagBits+1)'(RecipFull);

  logic signed [SampleBits-1:0] mem_q [DelayFrames];
  logic signed [SampleBits-1:0] rdata_q;
  logic signed [SumBits-1:0]    sum_q, sum_d;
  logic signed [SumBits-1:0]    acc_q, acc_d;
  logic signed [NumBits-1:0]    prod_q;
  logic signed [NumBits-1:0]    num;
  logic [DenBits-1:0]           den;
  logic                         div_busy;
  logic signed [NumBits-1:0]    quot;
  logic                         start;
  logic [SumBits-1:0]           sum_mag;
  logic [2*MagBits:0]           rprod_q;
  logic                         rneg_q;
  logic [SampleBits-1:0]        quo125;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.acc_clear) begin
      sum_d = acc_q;
    end else if (ctrl_i.acc_add) begin
      sum_d = sum_q + SumBits'(rdata_q);
    end
  end

  // Divide by 125 through the magnitude times a scaled reciprocal, then
  // restore the sign so the quotient truncates toward zero.
  assign sum_mag = sum_q[SumBits-1] ? -sum_q : sum_q;
  assign quo125  = rprod_q[2*MagBits:RecShift];

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_load) begin
      acc_d = rneg_q ? -SumBits'(quo125) : SumBits'(quo125);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    prod_q <= NumBits'(acc_q) * $signed({1'b0, wet_i});
    if (ctrl_i.div_start) begin
      rprod_q <= sum_mag[MagBits-1:0] * Recip;
      rneg_q  <= sum_q[SumBits-1];
    end
  end

  assign start = ctrl_i.mix_start;
  assign num   = (NumBits'(x_i) <<< smr_pkg::WetBits) + prod_q;
  assign den   = DenBits'(2**smr_pkg::WetBits) + DenBits'(wet_i);

  smr_divider #(
    .NumBits(NumBits),
    .DenBits(DenBits)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .num_i  (num),
    .den_i  (den),
    .busy_o (div_busy),
    .quot_o (quot)
  );

  logic signed [NumBits-1:0] y_full;
  assign y_full = mix_sel_i ? quot : NumBits'(x_i);
  always_comb begin
    if (y_full > OutMax) begin
      y_o = smr_pkg::OutBits'(OutMax);
    end else if (y_full < OutMin) begin
      y_o = smr_pkg::OutBits'(OutMin);
    end else begin
      y_o = smr_pkg::OutBits'(y_full);
    end
  end

  assign stat_o.busy = div_busy;

  `SMR_ASSERT_NEXT(a_div_starts, clk_i, rst_ni, start, div_busy, "divider failed to start")
  `SMR_ASSERT(a_no_start_busy, clk_i, rst_ni, !(start && div_busy), "divider restarted while busy")

endmodule

>>> src/stereo_multitap_reverb_core.sv
// Stereo multitap reverb core.
// Input words arrive on s_axis (tdata = {right_in, left_in}, left in the low
// bits); each accepted word yields exactly one output word on m_axis with the
// same packing. wet_level is written over the APB port at address 0; zero
// selects dry bypass, where the output equals the input.
// After reset a clearing pass writes zero to all DELAY_FRAMES entries of both
// delay memories, one entry per cycle, while s_axis is held not ready; APB
// writes are still taken.
// Throughput: one word at a time. A wet word streams the 125 taps through
// the registered memory read port, then runs the reciprocal /125, the
// accumulator load and the wet product, then the mix divide (NumBits =
// SAMPLE_BITS+26), and the result is registered in the output register.
// A dry word goes from the accept through the StOut state into the output
// register.
// Both channels run in parallel lanes, each with its own memory and divider;
// the output register joins the two lanes' results.
// When m_axis stalls the result holds in the output register and the next
// word is not taken until it leaves.
`include "stereo_multitap_reverb_core_macros.svh"
module stereo_multitap_reverb_core #(
  parameter int unsigned DELAY_FRAMES = smr_pkg::DelayFramesDef,
  parameter int unsigned SAMPLE_BITS  = smr_pkg::SampleBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // {right_in, left_in}, left_in at bit 0
  input  logic [2*SAMPLE_BITS-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // {right_out, left_out}, left_out at bit 0
  output logic [2*smr_pkg::OutBits-1:0] m_axis_tdata,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int unsigned AddrBits = $clog2(DELAY_FRAMES);
  localparam int unsigned TapBits  = $clog2(smr_pkg::TapCount + 1);
  localparam logic [AddrBits-1:0] LastAddr  = AddrBits'(DELAY_FRAMES - 1);
  localparam logic [AddrBits-1:0] WrapStart = AddrBits'(smr_pkg::ReadWrapStart);
  localparam logic [AddrBits-1:0] Spacing   = AddrBits'(smr_pkg::TapSpacing);

  smr_pkg::state_e state_q, state_d;
  logic [AddrBits-1:0] wp_q, rp_q, tap_addr_q, clr_q;
  logic [TapBits-1:0]  tap_cnt_q;
  logic                tap_valid_q;
  logic                mix_wait_q;
  logic [1:0]          div_step_q;
  logic [smr_pkg::WetBits-1:0] wet_q;
  logic signed [SAMPLE_BITS-1:0] xl_q, xr_q;
  logic                out_valid_q;
  logic [2*smr_pkg::OutBits-1:0] out_data_q;
  logic                wet_mode_q;

  smr_pkg::lane_ctrl_t ctrl;
  smr_pkg::lane_stat_t stat_l, stat_r;
  logic signed [smr_pkg::OutBits-1:0] yl, yr;
  logic                we;
  logic [AddrBits-1:0] waddr, raddr;
  logic signed [SAMPLE_BITS-1:0] wl, wr;
  logic                in_fire;

  // APB: single register, always ready.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == smr_pkg::RegWetLevel) ? 32'(wet_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wet_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == smr_pkg::RegWetLevel)) begin
      wet_q <= pwdata[smr_pkg::WetBits-1:0];
    end
  end

  assign s_axis_tready = (state_q == smr_pkg::StIdle) && !out_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Memory write: clearing pass or the incoming frame.
  assign we    = (state_q == smr_pkg::StClear) || in_fire;
  assign waddr = (state_q == smr_pkg::StClear) ? clr_q : wp_q;
  assign wl    = (state_q == smr_pkg::StClear) ? '0 : s_axis_tdata[SAMPLE_BITS-1:0];
  assign wr    = (state_q == smr_pkg::StClear) ? '0 : s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign raddr = tap_addr_q;

  // Sequencer.
  always_comb begin
    state_d        = state_q;
    ctrl           = '0;
    case (state_q)
      smr_pkg::StClear: if (clr_q == LastAddr) state_d = smr_pkg::StIdle;
      smr_pkg::StIdle: begin
        if (in_fire) begin
          state_d        = (wet_q != '0) ? smr_pkg::StTaps : smr_pkg::StOut;
          ctrl.acc_clear = (wet_q != '0);
        end
      end
      smr_pkg::StTaps: begin
        ctrl.acc_add = tap_valid_q;
        if (tap_valid_q && tap_cnt_q == TapBits'(1)) begin
          state_d = smr_pkg::StDiv;
        end
      end
      smr_pkg::StDiv: begin
        // Latch the reciprocal product, load the accumulator, then wait while
        // the registered wet product picks up the new accumulator.
        case (div_step_q)
          2'd0:    ctrl.div_start = 1'b1;
          2'd1:    ctrl.acc_load  = 1'b1;
          default: state_d = smr_pkg::StMix;
        endcase
      end
      smr_pkg::StMix: begin
        // Launch the mix divide on the first cycle, then wait for it.
        if (!mix_wait_q) begin
          ctrl.mix_start = 1'b1;
        end else if (!stat_l.busy && !stat_r.busy) begin
          state_d = smr_pkg::StOut;
        end
      end
      smr_pkg::StOut:  state_d = smr_pkg::StIdle;
      default:         state_d = smr_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smr_pkg::StClear;
      clr_q       <= '0;
      wp_q        <= '0;
      rp_q        <= WrapStart;
      tap_addr_q  <= '0;
      tap_cnt_q   <= '0;
      tap_valid_q <= 1'b0;
      mix_wait_q  <= 1'b0;
      div_step_q  <= '0;
      out_valid_q <= 1'b0;
      wet_mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == smr_pkg::StClear) begin
        clr_q <= clr_q + AddrBits'(1);
      end
      if (in_fire) begin
        wet_mode_q  <= (wet_q != '0);
        tap_addr_q  <= rp_q;
        tap_cnt_q   <= TapBits'(smr_pkg::TapCount);
        tap_valid_q <= 1'b0;
        wp_q        <= (wp_q == LastAddr) ? '0 : wp_q + AddrBits'(1);
        rp_q        <= (rp_q == LastAddr) ? WrapStart : rp_q + AddrBits'(1);
      end else if (state_q == smr_pkg::StTaps) begin
        // Step back one tap spacing; read data lands in the next cycle.
        tap_valid_q <= 1'b1;
        if (tap_valid_q) begin
          tap_cnt_q <= tap_cnt_q - TapBits'(1);
        end
        tap_addr_q <= (tap_addr_q >= Spacing) ? tap_addr_q - Spacing
                                              : tap_addr_q + AddrBits'(DELAY_FRAMES) - Spacing;
      end
      div_step_q <= (state_q == smr_pkg::StDiv) ? div_step_q + 2'd1 : 2'd0;
      mix_wait_q <= (state_q == smr_pkg::StMix) && (state_d == smr_pkg::StMix);
      if (state_q == smr_pkg::StOut) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      xl_q <= s_axis_tdata[SAMPLE_BITS-1:0];
      xr_q <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end
    if (state_q == smr_pkg::StOut) begin
      out_data_q <= {yr, yl};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  smr_lane #(.DelayFrames(DELAY_FRAMES), .SampleBits(SAMPLE_BITS), .AddrBits(AddrBits))
  u_lane_l (
    .clk_i, .rst_ni, .we_i(we), .waddr_i(waddr), .wdata_i(wl), .raddr_i(raddr),
    .ctrl_i(ctrl), .mix_sel_i(wet_mode_q), .x_i(xl_q), .wet_i(wet_q),
    .stat_o(stat_l), .y_o(yl)
  );

  smr_lane #(.DelayFrames(DELAY_FRAMES), .SampleBits(SAMPLE_BITS), .AddrBits(AddrBits))
  u_lane_r (
    .clk_i, .rst_ni, .we_i(we), .waddr_i(waddr), .wdata_i(wr), .raddr_i(raddr),
    .ctrl_i(ctrl), .mix_sel_i(wet_mode_q), .x_i(xr_q), .wet_i(wet_q),
    .stat_o(stat_r), .y_o(yr)
  );

  `SMR_ASSERT(a_lanes_lockstep, clk_i, rst_ni, stat_l.busy == stat_r.busy, "lanes out of step")
  `SMR_ASSERT(a_rp_floor, clk_i, rst_ni, rp_q >= WrapStart, "read pointer below wrap start")
  `SMR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !m_axis_tready, out_valid_q, "output word dropped")
  `SMR_ASSERT(a_no_accept_busy, clk_i, rst_ni, !(in_fire && out_valid_q), "word taken while result pending")

endmodule
